// ----- rtl/core/dqd_pkg.sv -----
// dqd_pkg: sizes, operation and status codes, and the per-cell command bundle
// for the double-ended queue with delete by value. No dependencies.
`default_nettype none

package dqd_pkg;

  // queue geometry
  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  // fixed port field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned HELD_W   = 5;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_DELETE     = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // broadcast to every cell in the row
  typedef struct packed {
    logic                  push_front;
    logic                  pop_front;
    logic                  del;
    logic [DATA_WIDTH-1:0] word;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/dqd_in_if.sv -----
// dqd_in_if: valid/ready channel carrying one operation beat.
// Depends on dqd_pkg.
`default_nettype none

interface dqd_in_if;
  import dqd_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dqd_out_if.sv -----
// dqd_out_if: valid/ready channel carrying one result beat.
// Depends on dqd_pkg.
`default_nettype none

interface dqd_out_if;
  import dqd_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  popped;
  logic [HELD_W-1:0]   entries_held;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output popped, output entries_held, output status,
                  input ready);
  modport sink   (input valid, input popped, input entries_held, input status,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dqd_cell.sv -----
// dqd_cell: one storage cell of the queue row; holds a word, compares it
// with the delete key and takes a neighbor's word on shifts. Depends on dqd_pkg.
`default_nettype none

module dqd_cell (
  input  logic                            clk_i,
  input  dqd_pkg::cell_cmd_t              cmd_i,
  input  logic                            held_i,
  input  logic                            tail_i,
  input  logic [dqd_pkg::DATA_WIDTH-1:0]  lower_i,
  input  logic [dqd_pkg::DATA_WIDTH-1:0]  upper_i,
  input  logic                            hit_i,
  output logic                            hit_o,
  output logic [dqd_pkg::DATA_WIDTH-1:0]  data_o
);
  import dqd_pkg::*;

  logic [DATA_WIDTH-1:0] data_d, data_q;
  logic                  match;

  // match against delete key, first-match chain toward the back
  assign match = cmd_i.del & held_i & (data_q == cmd_i.word);
  assign hit_o = hit_i | match;

  // next word: shift toward back, shift toward front, or load at the tail
  always_comb begin
    data_d = data_q;
    if (cmd_i.push_front) begin
      data_d = lower_i;
    end else if (cmd_i.pop_front || (cmd_i.del && hit_o)) begin
      data_d = upper_i;
    end else if (tail_i) begin
      data_d = cmd_i.word;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- rtl/core/deque_with_delete_by_value_unit.sv -----
// Bounded double-ended queue of CAPACITY words with push/pop at both ends and
// delete of the first entry (from the front) equal to a key. Every operation
// beat gives one result beat: popped word (0 unless a pop succeeded), count
// after the operation, and status (ok, pop on empty, push on full dropped,
// delete key not found). Storage is a row of cells that each compare their
// word and shift to a neighbor together, so an operation is accepted every
// cycle and its result appears in the next cycle in an output register;
// the input stalls only while that register holds a result not yet taken.
// Depends on dqd_pkg, dqd_in_if, dqd_out_if and dqd_cell.
`default_nettype none

module deque_with_delete_by_value_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  dqd_in_if.sink    in_i,
  dqd_out_if.source out_o
);
  import dqd_pkg::*;

  logic [CNT_W-1:0]      occ_d, occ_q;
  logic                  out_valid_q;
  logic [VALUE_W-1:0]    popped_d, popped_q;
  logic [CNT_W-1:0]      held_d;
  status_e               status_d, status_q;
  logic                  accept, full, empty, found;
  op_e                   op;
  cell_cmd_t             cmd;
  logic                  push_back;
  logic [IDX_W-1:0]      back_idx;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY:0]     hit_chain;

  // handshake: output register frees when its beat is taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign op       = op_e'(in_i.op);
  assign full     = (occ_q == CNT_W'(CAPACITY));
  assign empty    = (occ_q == '0);
  assign back_idx = IDX_W'(occ_q - CNT_W'(1));

  // commands broadcast to the cell row
  always_comb begin
    cmd.word       = DATA_WIDTH'(in_i.value);
    cmd.push_front = accept && (op == OP_PUSH_FRONT) && !full;
    cmd.pop_front  = accept && (op == OP_POP_FRONT) && !empty;
    cmd.del        = accept && (op == OP_DELETE);
  end
  assign push_back = accept && (op == OP_PUSH_BACK) && !full;

  // cell row, front at index 0
  assign hit_chain[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = cmd.word;
    end else begin : g_mid
      assign lower = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_inner
      assign upper = cell_data[i+1];
    end
    dqd_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .held_i  (CNT_W'(i) < occ_q),
      .tail_i  (push_back && (occ_q == CNT_W'(i))),
      .lower_i (lower),
      .upper_i (upper),
      .hit_i   (hit_chain[i]),
      .hit_o   (hit_chain[i+1]),
      .data_o  (cell_data[i])
    );
  end
  assign found = hit_chain[CAPACITY];

  // count update and result beat
  always_comb begin
    occ_d    = occ_q;
    popped_d = '0;
    status_d = ST_OK;
    unique case (op) inside
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          occ_d = occ_q + CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          occ_d    = occ_q - CNT_W'(1);
          popped_d = VALUE_W'(cell_data[back_idx]);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          occ_d    = occ_q - CNT_W'(1);
          popped_d = VALUE_W'(cell_data[0]);
        end
      end
      OP_DELETE: begin
        if (found) begin
          occ_d = occ_q - CNT_W'(1);
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      default: begin
        occ_d = occ_q;
      end
    endcase
    held_d = occ_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        occ_q <= occ_d;
      end
      if (in_i.ready) begin
        out_valid_q <= accept;
      end
    end
  end

  // result payload
  logic [CNT_W-1:0] held_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      held_q   <= held_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.popped       = popped_q;
  assign out_o.entries_held = HELD_W'(held_q);
  assign out_o.status       = status_q;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for deque_with_delete_by_value_unit, driving operation
// beats and checking result beats against a behavioral deque. Uses dqd_pkg, dqd_in_if, dqd_out_if.

module tb_top;
  import dqd_pkg::*;

  // op codes the block treats as no operation
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam int RANDOM_OPS = 1300;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    int                 gap;
    bit                 drain;
  } dq_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0] popped;
    logic [HELD_W-1:0]  held;
    status_e            status;
  } dq_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               tx_valid = 1'b0;
  logic [OP_W-1:0]    tx_op    = '0;
  logic [VALUE_W-1:0] tx_value = '0;
  logic               rx_ready = 1'b0;

  int issued_cnt  = 0;
  int retired_cnt = 0;
  int error_cnt   = 0;
  int hold_left   = 0;
  int hold_at     = 300;
  int rx_gap      = 0;
  int rx_calm     = 0;

  dq_op_t     op_backlog_q[$];
  dq_result_t deque_results_q[$];

  // behavioral copy of the queue contents
  logic [DATA_WIDTH-1:0] dq_slot [CAPACITY];
  int                    dq_count = 0;

  logic [VALUE_W-1:0] corner_words [8] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h7FFF_FFFF
  };

  dqd_in_if  in_if ();
  dqd_out_if out_if ();

  assign in_if.valid  = tx_valid;
  assign in_if.op     = tx_op;
  assign in_if.value  = tx_value;
  assign out_if.ready = rx_ready;

  deque_with_delete_by_value_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_cnt++;
  endtask

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // shift later entries toward the front over position pos
  function automatic void close_gap(input int pos);
    for (int i = pos; i + 1 < dq_count; i++) dq_slot[i] = dq_slot[i + 1];
    dq_count--;
  endfunction

  // apply one operation to the behavioral deque, return its result beat
  function automatic dq_result_t deque_apply(input logic [OP_W-1:0] op,
                                             input logic [VALUE_W-1:0] value);
    dq_result_t r;
    logic [DATA_WIDTH-1:0] word;
    int hit;
    r.popped = '0;
    r.status = ST_OK;
    word     = value[DATA_WIDTH-1:0];
    hit      = -1;
    case (op)
      OP_PUSH_BACK: begin
        if (dq_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          dq_slot[dq_count] = word;
          dq_count++;
        end
      end
      OP_POP_BACK: begin
        if (dq_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          dq_count--;
          r.popped = VALUE_W'(dq_slot[dq_count]);
        end
      end
      OP_PUSH_FRONT: begin
        if (dq_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = dq_count; i > 0; i--) dq_slot[i] = dq_slot[i - 1];
          dq_slot[0] = word;
          dq_count++;
        end
      end
      OP_POP_FRONT: begin
        if (dq_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = VALUE_W'(dq_slot[0]);
          close_gap(0);
        end
      end
      OP_DELETE: begin
        for (int i = 0; i < dq_count; i++) begin
          if (hit < 0 && dq_slot[i] == word) hit = i;
        end
        if (hit >= 0) close_gap(hit);
        else r.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    r.held = HELD_W'(dq_count);
    return r;
  endfunction

  task automatic queue_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                          input int gap, input bit drain);
    dq_op_t item;
    item.op    = op;
    item.value = value;
    item.gap   = gap;
    item.drain = drain;
    op_backlog_q.push_back(item);
  endtask

  // driver: offer the backlog head, predict each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_valid   <= 1'b0;
      issued_cnt <= 0;
    end else begin : tx_side
      logic offer;
      int   done_n;
      offer  = tx_valid;
      done_n = issued_cnt;
      if (tx_valid && in_if.ready) begin
        deque_results_q.push_back(deque_apply(tx_op, tx_value));
        done_n = done_n + 1;
        offer  = 1'b0;
      end
      if (!offer && op_backlog_q.size() != 0) begin
        if (op_backlog_q[0].gap != 0) begin
          op_backlog_q[0].gap = op_backlog_q[0].gap - 1;
        end else if (!(op_backlog_q[0].drain && done_n != retired_cnt)) begin
          tx_op    <= op_backlog_q[0].op;
          tx_value <= op_backlog_q[0].value;
          void'(op_backlog_q.pop_front());
          offer = 1'b1;
        end
      end
      tx_valid   <= offer;
      issued_cnt <= done_n;
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_at   <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (issued_cnt >= hold_at) begin
      hold_left <= 150;
      hold_at   <= hold_at + 500;
    end
  end

  // monitor: check each result beat, pace ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready    <= 1'b0;
      rx_gap      <= 0;
      rx_calm     <= 0;
      retired_cnt <= 0;
    end else begin : rx_side
      dq_result_t want;
      int gap_n;
      gap_n = rx_gap;
      if (out_if.valid && rx_ready) begin
        retired_cnt <= retired_cnt + 1;
        if (deque_results_q.size() == 0) begin
          flag_mismatch("result beat with no operation outstanding");
        end else begin
          want = deque_results_q.pop_front();
          if (out_if.popped !== want.popped)
            flag_mismatch($sformatf("popped %h, expected %h", out_if.popped, want.popped));
          if (out_if.entries_held !== want.held)
            flag_mismatch($sformatf("entries_held %0d, expected %0d",
                                    out_if.entries_held, want.held));
          if (out_if.status !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", out_if.status, want.status));
        end
        if (rx_calm != 0) begin
          gap_n = 0;
          rx_calm <= rx_calm - 1;
        end else begin
          gap_n = idle_len();
          if ($urandom_range(0, 39) == 0) rx_calm <= $urandom_range(20, 80);
        end
      end
      if (hold_left != 0) begin
        rx_ready <= 1'b0;
      end else if (gap_n != 0) begin
        rx_ready <= 1'b0;
        gap_n = gap_n - 1;
      end else begin
        rx_ready <= 1'b1;
      end
      rx_gap <= gap_n;
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    logic [VALUE_W-1:0] pool [8];
    logic [VALUE_W-1:0] val;
    logic [OP_W-1:0]    op;
    bit fill_mode;
    int phase_left;
    int calm_left;
    int gap;
    int r;
    int s;

    // empty queue corners
    queue_op(OP_POP_BACK, 32'h0000_0000, idle_len(), 1'b0);
    queue_op(OP_POP_FRONT, 32'hFFFF_FFFF, idle_len(), 1'b0);
    queue_op(OP_DELETE, 32'h0000_0000, idle_len(), 1'b0);
    queue_op(OP_UNUSED_LO, 32'hFFFF_FFFF, idle_len(), 1'b0);
    // fill from both ends with repeated words
    for (int i = 0; i < 8; i++) begin
      queue_op(OP_PUSH_BACK, corner_words[i], idle_len(), 1'b0);
      queue_op(OP_PUSH_FRONT, corner_words[7 - i], idle_len(), 1'b0);
    end
    // full queue corners
    queue_op(OP_PUSH_BACK, 32'hFFFF_FFFF, idle_len(), 1'b0);
    queue_op(OP_PUSH_FRONT, 32'h0000_0000, idle_len(), 1'b0);
    queue_op(OP_UNUSED_HI, 32'h1234_5678, idle_len(), 1'b0);
    // delete first of a duplicate, delete a missing word, pops
    queue_op(OP_DELETE, 32'h1234_5678, idle_len(), 1'b0);
    queue_op(OP_DELETE, 32'h0BAD_F00D, idle_len(), 1'b0);
    queue_op(OP_POP_BACK, 32'h0000_0000, idle_len(), 1'b0);
    queue_op(OP_POP_FRONT, 32'h0000_0000, 0, 1'b1);

    // random part: alternating fill and drain phases, words mostly from a small pool
    for (int i = 0; i < 8; i++) pool[i] = $urandom;
    pool[0]    = 32'h0000_0000;
    pool[1]    = 32'hFFFF_FFFF;
    fill_mode  = 1'b0;
    phase_left = 0;
    calm_left  = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (phase_left == 0) begin
        fill_mode  = !fill_mode;
        phase_left = $urandom_range(10, 60);
        pool[$urandom_range(2, 7)] = $urandom;
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (fill_mode) begin
        if (r < 35) op = OP_PUSH_BACK;
        else if (r < 70) op = OP_PUSH_FRONT;
        else if (r < 82) op = OP_DELETE;
        else if (r < 88) op = OP_POP_BACK;
        else if (r < 94) op = OP_POP_FRONT;
        else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else begin
        if (r < 35) op = OP_POP_BACK;
        else if (r < 70) op = OP_POP_FRONT;
        else if (r < 84) op = OP_DELETE;
        else if (r < 89) op = OP_PUSH_BACK;
        else if (r < 94) op = OP_PUSH_FRONT;
        else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end
      s = $urandom_range(0, 9);
      if (s < 5) val = pool[$urandom_range(0, 7)];
      else if (s == 5) val = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
      else val = $urandom;
      if (calm_left != 0) begin
        gap = 0;
        calm_left--;
      end else begin
        gap = idle_len();
        if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 60);
      end
      queue_op(op, val, gap, (n == 650) || ($urandom_range(0, 199) == 0));
    end

    // reset
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every beat to go through, then let the pipeline settle
    @(negedge clk_i);
    while (op_backlog_q.size() != 0 || tx_valid || issued_cnt != retired_cnt)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (deque_results_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", deque_results_q.size()));
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
